// ----- rtl/core/csfr_pkg.sv -----
package csfr_pkg;

    // Store geometry.
    localparam int LAYER_WIDTH  = 64;
    localparam int LAYER_HEIGHT = 64;
    localparam int DEPTH        = LAYER_WIDTH * LAYER_HEIGHT;
    localparam int XW           = $clog2(LAYER_WIDTH);
    localparam int YW           = $clog2(LAYER_HEIGHT);
    localparam int AW           = $clog2(DEPTH);

    // Field widths of the command and result beats.
    localparam int MODE_W = 2;
    localparam int POS_W  = 12;
    localparam int SIZE_W = 13;
    localparam int RAD_W  = 11;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 13;

    // Signed width for corner and bound arithmetic before clamping.
    localparam int CW = 16;

    // Largest distance from a pixel to a circle center, and the width of its square.
    localparam int DIST_MAX = (LAYER_WIDTH > LAYER_HEIGHT ? LAYER_WIDTH : LAYER_HEIGHT)
                              + (1 << (POS_W - 1));
    localparam int SQ_W     = 2 * $clog2(DIST_MAX);

    localparam logic [MODE_W-1:0] MODE_RECT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CIRCLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [SIZE_W-1:0]       size_w;
        logic [SIZE_W-1:0]       size_h;
        logic [RAD_W-1:0]        radius;
        logic [VAL_W-1:0]        fill_value;
    } t_cmd;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [CNT_W-1:0] pixels_written;
    } t_res;

    typedef struct packed {
        logic             we;
        logic [AW-1:0]    addr;
        logic [VAL_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic          re;
        logic [AW-1:0] addr;
    } t_rd_req;

    function automatic logic [XW-1:0] clamp_x(logic signed [CW-1:0] v);
        if (v < $signed(CW'(0))) begin
            clamp_x = '0;
        end else if (v > $signed(CW'(LAYER_WIDTH - 1))) begin
            clamp_x = XW'(LAYER_WIDTH - 1);
        end else begin
            clamp_x = v[XW-1:0];
        end
    endfunction

    function automatic logic [YW-1:0] clamp_y(logic signed [CW-1:0] v);
        if (v < $signed(CW'(0))) begin
            clamp_y = '0;
        end else if (v > $signed(CW'(LAYER_HEIGHT - 1))) begin
            clamp_y = YW'(LAYER_HEIGHT - 1);
        end else begin
            clamp_y = v[YW-1:0];
        end
    endfunction

    // Row-major word address of a pixel.
    function automatic logic [AW-1:0] pix_addr(logic [YW-1:0] y, logic [XW-1:0] x);
        pix_addr = AW'(AW'(y) * AW'(LAYER_WIDTH) + AW'(x));
    endfunction

endpackage

// ----- rtl/core/csfr_ifs.sv -----
interface csfr_cmd_if;
    logic             valid;
    logic             ready;
    csfr_pkg::t_cmd   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface csfr_res_if;
    logic             valid;
    logic             ready;
    csfr_pkg::t_res   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/csfr_store.sv -----
module csfr_store (
    input  logic                            i_clk,
    input  csfr_pkg::t_wr_req               i_wr,
    input  csfr_pkg::t_rd_req               i_rd,
    output logic [csfr_pkg::VAL_W-1:0]      o_rdata
);

    logic [csfr_pkg::VAL_W-1:0] r_mem [csfr_pkg::DEPTH];
    logic [csfr_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/csfr_walk.sv -----
module csfr_walk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  csfr_pkg::t_cmd                  i_cmd,
    output logic                            o_cmd_ready,
    output logic                            o_done,
    output csfr_pkg::t_res                  o_res,
    input  logic                            i_slot_free,
    output csfr_pkg::t_wr_req               o_wr,
    output csfr_pkg::t_rd_req               o_rd,
    input  logic [csfr_pkg::VAL_W-1:0]      i_rdata
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_READ  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                             r_state, n_state;
    logic [csfr_pkg::AW-1:0]            r_clr_addr;
    csfr_pkg::t_cmd                     r_cmd;
    logic [csfr_pkg::XW-1:0]            r_x, r_x0, r_x1;
    logic [csfr_pkg::YW-1:0]            r_y, r_y1;
    logic [csfr_pkg::SQ_W-1:0]          r_r2;
    logic                               r_a_valid;
    logic [csfr_pkg::AW-1:0]            r_a_addr;
    logic [csfr_pkg::SQ_W-1:0]          r_a_dx2, r_a_dy2;
    logic [csfr_pkg::CNT_W-1:0]         r_count;
    logic [csfr_pkg::VAL_W-1:0]         r_rdata;

    logic signed [csfr_pkg::CW-1:0]     s_px, s_py, s_r, s_w, s_h;
    logic signed [csfr_pkg::CW-1:0]     s_rx_end, s_ry_end;
    logic [csfr_pkg::XW-1:0]            rx0, bx0, bx1;
    logic [csfr_pkg::YW-1:0]            ry0, by0, by1;
    logic                               rect_empty;
    logic                               last_px;
    logic signed [csfr_pkg::CW-1:0]     dx, dy;
    logic signed [2*csfr_pkg::CW-1:0]   dx_prod, dy_prod;
    logic [csfr_pkg::SQ_W:0]            dist_sum;
    logic                               hit;

    // Command fields widened for bound arithmetic.
    assign s_px = {{(csfr_pkg::CW - csfr_pkg::POS_W){r_cmd.pos_x[csfr_pkg::POS_W-1]}},
                   r_cmd.pos_x};
    assign s_py = {{(csfr_pkg::CW - csfr_pkg::POS_W){r_cmd.pos_y[csfr_pkg::POS_W-1]}},
                   r_cmd.pos_y};
    assign s_r  = $signed(csfr_pkg::CW'(r_cmd.radius));
    assign s_w  = $signed(csfr_pkg::CW'(r_cmd.size_w));
    assign s_h  = $signed(csfr_pkg::CW'(r_cmd.size_h));

    // The far rectangle edge is measured from the already clamped corner.
    assign rx0      = csfr_pkg::clamp_x(s_px);
    assign ry0      = csfr_pkg::clamp_y(s_py);
    assign s_rx_end = $signed(csfr_pkg::CW'(rx0)) + s_w - $signed(csfr_pkg::CW'(1));
    assign s_ry_end = $signed(csfr_pkg::CW'(ry0)) + s_h - $signed(csfr_pkg::CW'(1));

    always_comb begin
        if (r_cmd.mode == csfr_pkg::MODE_RECT) begin
            bx0 = rx0;
            by0 = ry0;
            bx1 = csfr_pkg::clamp_x(s_rx_end);
            by1 = csfr_pkg::clamp_y(s_ry_end);
        end else begin
            bx0 = csfr_pkg::clamp_x(s_px - s_r);
            by0 = csfr_pkg::clamp_y(s_py - s_r);
            bx1 = csfr_pkg::clamp_x(s_px + s_r);
            by1 = csfr_pkg::clamp_y(s_py + s_r);
        end
    end

    assign rect_empty = (r_cmd.size_w == '0) || (r_cmd.size_h == '0);
    assign last_px    = (r_x == r_x1) && (r_y == r_y1);

    // First pipe stage: offsets from the center, squared.
    assign dx      = $signed(csfr_pkg::CW'(r_x)) - s_px;
    assign dy      = $signed(csfr_pkg::CW'(r_y)) - s_py;
    assign dx_prod = dx * dx;
    assign dy_prod = dy * dy;

    // Second pipe stage: distance test and write.
    assign dist_sum = {1'b0, r_a_dx2} + {1'b0, r_a_dy2};
    assign hit      = r_a_valid &&
                      ((r_cmd.mode == csfr_pkg::MODE_RECT) || (dist_sum <= {1'b0, r_r2}));

    always_comb begin
        if (r_state == S_CLEAR) begin
            o_wr.we   = 1'b1;
            o_wr.addr = r_clr_addr;
            o_wr.data = '0;
        end else begin
            o_wr.we   = hit;
            o_wr.addr = r_a_addr;
            o_wr.data = r_cmd.fill_value;
        end
    end

    assign o_rd.re   = (r_state == S_SETUP) && (r_cmd.mode == csfr_pkg::MODE_READ);
    assign o_rd.addr = csfr_pkg::pix_addr(ry0, rx0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == csfr_pkg::AW'(csfr_pkg::DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                case (r_cmd.mode)
                    csfr_pkg::MODE_RECT:   n_state = rect_empty ? S_DONE : S_SCAN;
                    csfr_pkg::MODE_CIRCLE: n_state = S_SCAN;
                    csfr_pkg::MODE_READ:   n_state = S_READ;
                    default:               n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (last_px) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_READ:  n_state = S_DONE;
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_a_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= r_clr_addr + 1'b1;
            r_a_valid  <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_addr <= csfr_pkg::pix_addr(r_y, r_x);
        r_a_dx2  <= dx_prod[csfr_pkg::SQ_W-1:0];
        r_a_dy2  <= dy_prod[csfr_pkg::SQ_W-1:0];

        if (hit && (r_count != '1)) begin
            r_count <= r_count + 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                r_cmd   <= i_cmd;
                r_count <= '0;
                r_rdata <= '0;
            end
            S_SETUP: begin
                r_x  <= bx0;
                r_x0 <= bx0;
                r_x1 <= bx1;
                r_y  <= by0;
                r_y1 <= by1;
                r_r2 <= csfr_pkg::SQ_W'(r_cmd.radius) * csfr_pkg::SQ_W'(r_cmd.radius);
            end
            S_SCAN: begin
                if (r_x == r_x1) begin
                    r_x <= r_x0;
                    r_y <= r_y + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            S_READ: begin
                r_rdata <= i_rdata;
            end
            default: begin
            end
        endcase
    end

    assign o_cmd_ready          = (r_state == S_IDLE);
    assign o_done               = (r_state == S_DONE);
    assign o_res.read_value     = r_rdata;
    assign o_res.pixels_written = r_count;

endmodule

// ----- rtl/core/clipped_shape_fill_raster.sv -----
// Clipped rectangle and circle fill over a 64 by 64 store of 32-bit pixels.
// Commands arrive on i_cmd (valid/ready); each beat is a rectangle fill, a
// circle fill or a read of one pixel. Every command yields exactly one result
// beat on o_res (valid/ready) with the pixel read and the pixels written.
// The store is a single-port-write, single-port-read memory with a registered
// read output; fills walk the clamped bounding box one pixel per cycle
// through a two-stage pipe (offset squares, then distance test and write).
// A fill scans every pixel of the box; a read takes the word at the clamped
// position; an empty rectangle or an unused mode writes nothing and goes
// straight to its result.
// One command is in work at a time and the next one is accepted only after
// the result of the last has moved into the output register.
// After reset the store is cleared one word per cycle, all LAYER_WIDTH times
// LAYER_HEIGHT words, while i_cmd.ready stays low.
// A result waits in an output register while the receiver stalls; the next
// command is still accepted and worked, and its result holds in the walker
// until the output register frees up.
module clipped_shape_fill_raster (
    input  logic            i_clk,
    input  logic            i_rst_n,
    csfr_cmd_if.sink        i_cmd,
    csfr_res_if.source      o_res
);

    csfr_pkg::t_wr_req              wr_req;
    csfr_pkg::t_rd_req              rd_req;
    logic [csfr_pkg::VAL_W-1:0]     rdata;
    logic                           cmd_ready;
    logic                           done;
    csfr_pkg::t_res                 walk_res;
    logic                           slot_free;

    logic                           r_res_valid;
    csfr_pkg::t_res                 r_res;

    csfr_store u_store (
        .i_clk   (i_clk),
        .i_wr    (wr_req),
        .i_rd    (rd_req),
        .o_rdata (rdata)
    );

    csfr_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .i_cmd       (i_cmd.data),
        .o_cmd_ready (cmd_ready),
        .o_done      (done),
        .o_res       (walk_res),
        .i_slot_free (slot_free),
        .o_wr        (wr_req),
        .o_rd        (rd_req),
        .i_rdata     (rdata)
    );

    assign slot_free = !r_res_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (done && slot_free) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && slot_free) begin
            r_res <= walk_res;
        end
    end

    assign i_cmd.ready = cmd_ready;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

endmodule

// ----- tb/clipped_shape_fill_raster_checker.sv -----
`timescale 1ns / 100ps
module clipped_shape_fill_raster_checker
    import csfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    csfr_cmd_if  i_cmd,
    csfr_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int CNT_MAX = (1 << CNT_W) - 1;

    logic [VAL_W-1:0] pixel_mirror [DEPTH];
    t_res             awaited_results [$];
    int               error_count = 0;

    function automatic int clamp_to(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    // Applies one command to the mirrored store and returns the beat it must produce.
    function automatic t_res paint_and_count(t_cmd c);
        t_res r;
        int   px, py, x0, y0, x1, y1, rad, dx, dy, n;
        px = int'($signed(c.pos_x));
        py = int'($signed(c.pos_y));
        r  = '0;
        n  = 0;
        case (c.mode)
            MODE_RECT: begin
                if (c.size_w != 0 && c.size_h != 0) begin
                    x0 = clamp_to(px, LAYER_WIDTH - 1);
                    y0 = clamp_to(py, LAYER_HEIGHT - 1);
                    x1 = clamp_to(x0 + int'(c.size_w) - 1, LAYER_WIDTH - 1);
                    y1 = clamp_to(y0 + int'(c.size_h) - 1, LAYER_HEIGHT - 1);
                    for (int y = y0; y <= y1; y++) begin
                        for (int x = x0; x <= x1; x++) begin
                            pixel_mirror[y * LAYER_WIDTH + x] = c.fill_value;
                            n++;
                        end
                    end
                end
            end
            MODE_CIRCLE: begin
                rad = int'(c.radius);
                x0  = clamp_to(px - rad, LAYER_WIDTH - 1);
                y0  = clamp_to(py - rad, LAYER_HEIGHT - 1);
                x1  = clamp_to(px + rad, LAYER_WIDTH - 1);
                y1  = clamp_to(py + rad, LAYER_HEIGHT - 1);
                for (int y = y0; y <= y1; y++) begin
                    for (int x = x0; x <= x1; x++) begin
                        dx = x - px;
                        dy = y - py;
                        if (dx * dx + dy * dy <= rad * rad) begin
                            pixel_mirror[y * LAYER_WIDTH + x] = c.fill_value;
                            n++;
                        end
                    end
                end
            end
            MODE_READ: begin
                r.read_value = pixel_mirror[clamp_to(py, LAYER_HEIGHT - 1) * LAYER_WIDTH
                                            + clamp_to(px, LAYER_WIDTH - 1)];
            end
            default: ;
        endcase
        r.pixels_written = CNT_W'((n > CNT_MAX) ? CNT_MAX : n);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            foreach (pixel_mirror[i]) pixel_mirror[i] = '0;
            awaited_results.delete();
        end else begin
            // Results retire before the command of the same edge is applied; a result
            // can never belong to a command accepted at that very edge.
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result beat read_value %08h pixels_written %0d",
                             $time, got.read_value, got.pixels_written);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %08h, got %08h",
                                 $time, want.read_value, got.read_value);
                        error_count++;
                    end
                    if (got.pixels_written !== want.pixels_written) begin
                        $display("%0t: pixels_written expected %0d, got %0d",
                                 $time, want.pixels_written, got.pixels_written);
                        error_count++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                awaited_results.push_back(paint_and_count(i_cmd.data));
            end
        end
        o_fail_count <= error_count;
        o_pending    <= awaited_results.size();
    end

endmodule

// ----- tb/clipped_shape_fill_raster_test.sv -----
`timescale 1ns / 100ps
module clipped_shape_fill_raster_test;
    import csfr_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 120;
    // A full-store fill plus the clearing pass after reset, taken more than twice over.
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   stall_cycles = 0;
    int   ready_hold   = 0;
    bit   calm_phase   = 1'b0;

    csfr_cmd_if cmd_bus ();
    csfr_res_if res_bus ();

    clipped_shape_fill_raster i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    clipped_shape_fill_raster_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int draw_gap();
        return calm_phase ? 0 : int'($urandom_range(0, 8));
    endfunction

    // The receiver stalls a new random count after each result beat, none when calm.
    always @(posedge i_clk) begin
        if (res_bus.valid && res_bus.ready) ready_hold = draw_gap();
    end

    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            res_bus.ready <= 1'b0;
            ready_hold--;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.data  <= c;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [MODE_W-1:0] mode, input int x, input int y,
                         input int w, input int h, input int rad,
                         input logic [VAL_W-1:0] value);
        t_cmd c;
        c.mode       = mode;
        c.pos_x      = POS_W'(x);
        c.pos_y      = POS_W'(y);
        c.size_w     = SIZE_W'(w);
        c.size_h     = SIZE_W'(h);
        c.radius     = RAD_W'(rad);
        c.fill_value = value;
        send_cmd(c);
    endtask

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            c.mode = MODE_READ;
        end else if (pick < 65) begin
            c.mode = MODE_RECT;
        end else if (pick < 94) begin
            c.mode = MODE_CIRCLE;
        end else begin
            c.mode = MODE_SPARE;
        end
        // Mostly near the store so that reads see earlier fills; now and then anywhere.
        if ($urandom_range(0, 7) == 0) begin
            c.pos_x = POS_W'($urandom());
            c.pos_y = POS_W'($urandom());
        end else begin
            c.pos_x = POS_W'(int'($urandom_range(0, LAYER_WIDTH + 15)) - 8);
            c.pos_y = POS_W'(int'($urandom_range(0, LAYER_HEIGHT + 15)) - 8);
        end
        c.size_w = SIZE_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191)
                                                        : $urandom_range(0, 12));
        c.size_h = SIZE_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191)
                                                        : $urandom_range(0, 12));
        c.radius = RAD_W'(($urandom_range(0, 11) == 0) ? $urandom_range(0, 2047)
                                                       : $urandom_range(0, 9));
        c.fill_value = $urandom();
        return c;
    endfunction

    initial begin
        cmd_bus.valid = 1'b0;
        cmd_bus.data  = '0;
        res_bus.ready = 1'b0;
        i_rst_n       = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: corners, clamping, empty shapes, whole-store shapes, the spare mode.
        issue(MODE_READ,   0, 0, 1, 1, 0, 32'h0);
        issue(MODE_RECT,   -2048, -2048, 1, 1, 0, 32'hFFFF_FFFF);
        issue(MODE_READ,   -2048, -2048, 1, 1, 0, 32'h0);
        issue(MODE_RECT,   5, 5, 0, 5, 0, 32'hDEAD_BEEF);
        issue(MODE_RECT,   5, 5, 5, 0, 0, 32'hDEAD_BEEF);
        issue(MODE_READ,   5, 5, 1, 1, 0, 32'h0);
        issue(MODE_RECT,   2047, 2047, 8191, 8191, 0, 32'hA5A5_5A5A);
        issue(MODE_READ,   2047, 2047, 0, 0, 0, 32'h0);
        issue(MODE_RECT,   0, 0, 4096, 4096, 0, 32'h1234_5678);
        issue(MODE_RECT,   10, 20, 5, 3, 0, 32'h0000_0000);
        issue(MODE_READ,   12, 21, 0, 0, 0, 32'h0);
        issue(MODE_RECT,   60, -5, 9, 9, 0, 32'h5555_AAAA);
        issue(MODE_CIRCLE, 5, 5, 0, 0, 0, 32'h0F0F_0F0F);
        issue(MODE_CIRCLE, -1, 5, 0, 0, 0, 32'hF0F0_F0F0);
        issue(MODE_CIRCLE, -2048, -2048, 0, 0, 5, 32'h3333_3333);
        issue(MODE_CIRCLE, 31, 31, 0, 0, 2047, 32'h8000_0001);
        issue(MODE_CIRCLE, 2047, 30, 0, 0, 2047, 32'h7FFF_FFFE);
        issue(MODE_CIRCLE, 32, 32, 0, 0, 10, 32'hCAFE_F00D);
        issue(MODE_CIRCLE, 70, 10, 0, 0, 7, 32'h1111_2222);
        issue(MODE_SPARE,  -2048, 2047, 8191, 8191, 2047, 32'hFFFF_FFFF);
        issue(MODE_READ,   -1, 64, 0, 0, 0, 32'h0);
        issue(MODE_READ,   32, 42, 0, 0, 0, 32'h0);
        issue(MODE_READ,   63, 0, 0, 0, 0, 32'h0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 25 == 0) calm_phase = ($urandom_range(0, 2) == 0);
            send_cmd(random_cmd());
        end
        calm_phase = 1'b0;
        cmd_bus.valid <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
